[design/spf_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the servo packet framer.
package spf_pkg;

   // Largest number of parameter bytes in one packet.
   localparam int unsigned MAX_PARAMS = 64;

   // Field widths.
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned CRC_W   = 16;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned STEP_W  = 4;
   localparam int unsigned INDEX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [INDEX_W-1:0] REG_SERVO_ID    = 2'd0;
   localparam logic [INDEX_W-1:0] REG_INSTRUCTION = 2'd1;
   localparam logic [INDEX_W-1:0] REG_PARAM_COUNT = 2'd2;

   // Register reset values.
   localparam logic [BYTE_W-1:0]  SERVO_ID_RESET    = 8'd1;
   localparam logic [BYTE_W-1:0]  INSTRUCTION_RESET = 8'd3;
   localparam logic [COUNT_W-1:0] PARAM_COUNT_RESET = 7'd3;

   // Clamp bound for the parameter count, in the count's width.
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PARAMS);

   // Packet constants.
   localparam logic [BYTE_W-1:0] HDR_SYNC     = 8'hFF;
   localparam logic [BYTE_W-1:0] HDR_MARK     = 8'hFD;
   localparam logic [BYTE_W-1:0] HDR_RESERVED = 8'h00;
   localparam logic [LEN_W-1:0]  LEN_EXTRA    = 16'd3;
   localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h8005;
   localparam logic [CRC_W-1:0]  CRC_INIT     = 16'h0000;

   // Byte positions within the bytes caused by one parameter.
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_SYNC0    = 4'd0;
   localparam step_type STEP_SYNC1    = 4'd1;
   localparam step_type STEP_MARK     = 4'd2;
   localparam step_type STEP_RESERVED = 4'd3;
   localparam step_type STEP_ID       = 4'd4;
   localparam step_type STEP_LEN_LO   = 4'd5;
   localparam step_type STEP_LEN_HI   = 4'd6;
   localparam step_type STEP_INSTR    = 4'd7;
   localparam step_type STEP_PARAM    = 4'd8;
   localparam step_type STEP_CRC_LO   = 4'd9;
   localparam step_type STEP_CRC_HI   = 4'd10;

   // Live configuration handed from the register file to the framer.
   typedef struct packed {
      logic [BYTE_W-1:0]  servo_id;
      logic [BYTE_W-1:0]  instruction;
      logic [COUNT_W-1:0] count;
   } cfg_type;

   // One byte of CRC-16, MSB first, no reflection.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] acc;
      acc = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (acc[CRC_W-1]) begin
            acc = {acc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[CRC_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

[design/spf_csr.sv]
// Configuration registers of the servo packet framer and the effective count.
module spf_csr #(
   parameter int unsigned MAX_PARAMS = spf_pkg::MAX_PARAMS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [spf_pkg::INDEX_W-1:0]  csr_index,
   input  logic [spf_pkg::BYTE_W-1:0]   csr_data,
   output spf_pkg::cfg_type             cfg
);
   import spf_pkg::*;

   // Clamp bound, limited to what the count register can hold.
   localparam int unsigned COUNT_CAP =
      (MAX_PARAMS < (1 << COUNT_W)) ? MAX_PARAMS : (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_CAP);

   logic [BYTE_W-1:0]  servo_id_ff;
   logic [BYTE_W-1:0]  instruction_ff;
   logic [COUNT_W-1:0] param_count_ff;
   logic [COUNT_W-1:0] count_clamped;

   // Writes are taken at once whenever the block is out of reset.
   assign csr_ready = !reset;

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         servo_id_ff    <= SERVO_ID_RESET;
         instruction_ff <= INSTRUCTION_RESET;
         param_count_ff <= PARAM_COUNT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SERVO_ID:    servo_id_ff    <= csr_data;
            REG_INSTRUCTION: instruction_ff <= csr_data;
            REG_PARAM_COUNT: param_count_ff <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Saturate the count into one through the packet limit.
   always_comb begin
      count_clamped = param_count_ff;
      if (param_count_ff == '0) begin
         count_clamped = COUNT_W'(1);
      end else if (param_count_ff > COUNT_LIMIT) begin
         count_clamped = COUNT_LIMIT;
      end
   end

   assign cfg.servo_id    = servo_id_ff;
   assign cfg.instruction = instruction_ff;
   assign cfg.count       = count_clamped;

endmodule

[design/spf_framer.sv]
// Packet sequencer: holds one parameter, emits its bytes and keeps the running CRC.
module spf_framer (
   input  logic                        clock,
   input  logic                        reset,
   input  spf_pkg::cfg_type            cfg,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [spf_pkg::BYTE_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [spf_pkg::BYTE_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast
);
   import spf_pkg::*;

   // Control state.
   logic               busy_ff, busy_in;
   step_type           step_ff, step_in;
   logic [COUNT_W-1:0] index_ff, index_in;
   logic               out_valid_ff, out_valid_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;

   // Held item and its output byte.
   logic [BYTE_W-1:0]  param_ff;
   logic               last_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               out_end_ff;

   logic               accept;
   logic               load;
   logic               final_step;
   logic               first;
   logic [COUNT_W-1:0] index_next;
   logic               item_last;
   logic [BYTE_W-1:0]  cur_byte;
   logic               cur_end;

   // Handshake: a byte moves into the output register when it is empty or drained.
   assign load       = busy_ff && (!out_valid_ff || rsp_tready);
   assign final_step = (step_ff == (last_ff ? STEP_CRC_HI : STEP_PARAM));
   assign req_tready = !reset && (!busy_ff || (load && final_step));
   assign accept     = req_tvalid && req_tready;

   // Packet position of the incoming parameter.
   assign first      = (index_ff == '0);
   assign index_next = index_ff + COUNT_W'(1);
   assign item_last  = (index_next >= cfg.count);

   // Byte for the current step.
   always_comb begin
      cur_end = 1'b0;
      case (step_ff)
         STEP_SYNC0:    cur_byte = HDR_SYNC;
         STEP_SYNC1:    cur_byte = HDR_SYNC;
         STEP_MARK:     cur_byte = HDR_MARK;
         STEP_RESERVED: cur_byte = HDR_RESERVED;
         STEP_ID:       cur_byte = cfg.servo_id;
         STEP_LEN_LO:   cur_byte = len_ff[7:0];
         STEP_LEN_HI:   cur_byte = len_ff[15:8];
         STEP_INSTR:    cur_byte = cfg.instruction;
         STEP_PARAM:    cur_byte = param_ff;
         STEP_CRC_LO:   cur_byte = crc_ff[7:0];
         STEP_CRC_HI: begin
            cur_byte = crc_ff[15:8];
            cur_end  = 1'b1;
         end
         default:       cur_byte = HDR_RESERVED;
      endcase
   end

   // Next control state.
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      index_in     = index_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         // Data bytes feed the CRC; the header restarts it.
         if (step_ff <= STEP_PARAM) begin
            crc_in = crc_byte((step_ff == STEP_SYNC0) ? CRC_INIT : crc_ff, cur_byte);
         end
         if (final_step) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
      if (accept) begin
         busy_in  = 1'b1;
         step_in  = first ? STEP_SYNC0 : STEP_PARAM;
         index_in = item_last ? '0 : index_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_SYNC0;
         index_ff     <= '0;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         index_ff     <= index_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Item and output payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         param_ff <= req_tdata;
         last_ff  <= item_last;
         if (first) begin
            len_ff <= LEN_W'(cfg.count) + LEN_EXTRA;
         end
      end
      if (load) begin
         out_byte_ff <= cur_byte;
         out_end_ff  <= cur_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_end_ff;

endmodule

[design/servo_packet_framer_crc16_top.sv]
// Servo packet framer top level: parameter bytes in, framed packet bytes with CRC-16 out.
//
// Usage:
//   req_*  carries one parameter byte per transaction. The first parameter of a
//          packet is preceded on the output by FF FF FD 00, the servo id, the
//          little-endian length (count + 3) and the instruction byte.
//   rsp_*  carries one packet byte per transaction; after the last parameter the
//          CRC-16 (poly 0x8005, init 0) follows low byte first, and rsp_tlast
//          marks its high byte.
//   csr_*  writes servo id (0), instruction (1) and parameter count (2). Write
//          only while no packet byte is pending. Other indexes are ignored.
// Timing: an item's first byte passes the sequencer state, then the output register.
//   While rsp_tready allows, the sequencer emits one byte per cycle; an item is 1, 3,
//   9 or 11 bytes (parameter only, plus CRC, plus header, or all three). The next item
//   is accepted in the cycle that the last byte enters the output register.
// Reset clears the packet position, the CRC and the output valid flag and loads
//   the register defaults (id 1, instruction 3, count 3).
// When rsp_tready is low the output byte holds and the sequencer waits.
module servo_packet_framer_crc16_top #(
   parameter int unsigned MAX_PARAMS = spf_pkg::MAX_PARAMS
) (
   input  logic                        clock,
   input  logic                        reset,
   // Configuration write channel.
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [spf_pkg::INDEX_W-1:0] csr_index,
   input  logic [spf_pkg::BYTE_W-1:0]  csr_data,
   // Parameter byte stream.
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [spf_pkg::BYTE_W-1:0]  req_tdata,   // [7:0] param_byte
   // Packet byte stream.
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [spf_pkg::BYTE_W-1:0]  rsp_tdata,   // [7:0] tx_byte
   output logic                        rsp_tlast    // packet_end
);
   import spf_pkg::*;

   cfg_type cfg;

   // Configuration registers.
   spf_csr #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Byte sequencer and CRC.
   spf_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[tb/sv/tb_servo_packet_framer_crc16_top.sv]
// Self-checking testbench for the servo packet framer with its CRC-16 trailer.
`timescale 1ns / 1ps

module tb_servo_packet_framer_crc16_top;
   import spf_pkg::*;

   // Register index that the block does not decode.
   localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

   // Stimulus volume and pacing.
   localparam int ITEM_TARGET  = 470;
   localparam int IDLE_PERCENT = 13;
   localparam int HOLD_START   = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_LIMIT  = 20000;

   typedef enum logic {ROW_WRITE, ROW_PARAM} row_kind_type;

   // One directed step: a register write, or a parameter byte with optional
   // typed-in values for the id and length-low header bytes.
   typedef struct packed {
      row_kind_type       kind;
      logic [INDEX_W-1:0] index;
      logic [BYTE_W-1:0]  value;
      logic               pin_en;
      logic [BYTE_W-1:0]  pin_id;
      logic [BYTE_W-1:0]  pin_len;
   } row_type;

   localparam int PLAN_LEN = 25;
   localparam row_type PLAN [0:PLAN_LEN-1] = '{
      // Reset defaults: id 1, count 3, so the length low byte is 6.
      '{ROW_PARAM, 2'd0,            8'h00, 1'b1, 8'h01, 8'h06},
      '{ROW_PARAM, 2'd0,            8'hFF, 1'b0, 8'h00, 8'h00},
      '{ROW_PARAM, 2'd0,            8'h5A, 1'b0, 8'h00, 8'h00},
      // Smallest id and smallest packet.
      '{ROW_WRITE, REG_SERVO_ID,    8'h00, 1'b0, 8'h00, 8'h00},
      '{ROW_WRITE, REG_PARAM_COUNT, 8'h01, 1'b0, 8'h00, 8'h00},
      '{ROW_PARAM, 2'd0,            8'h80, 1'b1, 8'h00, 8'h04},
      // Largest legal id, largest instruction, and a count of zero acting as one.
      '{ROW_WRITE, REG_SERVO_ID,    8'hFC, 1'b0, 8'h00, 8'h00},
      '{ROW_WRITE, REG_INSTRUCTION, 8'hFF, 1'b0, 8'h00, 8'h00},
      '{ROW_WRITE, REG_PARAM_COUNT, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ROW_PARAM, 2'd0,            8'h01, 1'b1, 8'hFC, 8'h04},
      // Id above the legal range passes through; an oversized count saturates.
      '{ROW_WRITE, REG_SERVO_ID,    8'hFF, 1'b0, 8'h00, 8'h00},
      '{ROW_WRITE, REG_PARAM_COUNT, 8'h7F, 1'b0, 8'h00, 8'h00},
      '{ROW_PARAM, 2'd0,            8'h7F, 1'b1, 8'hFF, 8'h43},
      // Count lowered in the middle of a packet ends it on the next parameter.
      '{ROW_WRITE, REG_PARAM_COUNT, 8'h02, 1'b0, 8'h00, 8'h00},
      '{ROW_PARAM, 2'd0,            8'h33, 1'b0, 8'h00, 8'h00},
      // Bit 7 of a count write falls outside the register.
      '{ROW_WRITE, REG_INSTRUCTION, 8'h00, 1'b0, 8'h00, 8'h00},
      '{ROW_WRITE, REG_PARAM_COUNT, 8'h85, 1'b0, 8'h00, 8'h00},
      '{ROW_PARAM, 2'd0,            8'hAA, 1'b1, 8'hFF, 8'h08},
      '{ROW_PARAM, 2'd0,            8'h55, 1'b0, 8'h00, 8'h00},
      // Count raised mid-packet, then dropped below the position reached.
      '{ROW_WRITE, REG_PARAM_COUNT, 8'h40, 1'b0, 8'h00, 8'h00},
      '{ROW_PARAM, 2'd0,            8'hC3, 1'b0, 8'h00, 8'h00},
      '{ROW_WRITE, REG_PARAM_COUNT, 8'h01, 1'b0, 8'h00, 8'h00},
      '{ROW_PARAM, 2'd0,            8'h3C, 1'b0, 8'h00, 8'h00},
      // A write to an undecoded index must leave every register alone.
      '{ROW_WRITE, REG_UNUSED,      8'hFF, 1'b0, 8'h00, 8'h00},
      '{ROW_PARAM, 2'd0,            8'h99, 1'b1, 8'hFF, 8'h04}
   };

   // One expected packet byte.
   typedef struct {
      logic [BYTE_W-1:0] tx_byte;
      logic              packet_end;
   } tx_beat_type;

   // Block ports, all driven to known values from time zero.
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [INDEX_W-1:0] csr_index  = '0;
   logic [BYTE_W-1:0]  csr_data   = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [BYTE_W-1:0]  rsp_tdata;
   logic               rsp_tlast;

   // Typed-in header values that travel alongside each parameter transaction.
   logic              req_pin_en  = 1'b0;
   logic [BYTE_W-1:0] req_pin_id  = '0;
   logic [BYTE_W-1:0] req_pin_len = '0;

   // Predictor copy of the registers and the packet state.
   logic [BYTE_W-1:0]  cfg_servo_id = SERVO_ID_RESET;
   logic [BYTE_W-1:0]  cfg_instr    = INSTRUCTION_RESET;
   logic [COUNT_W-1:0] cfg_count    = PARAM_COUNT_RESET;
   logic [COUNT_W-1:0] fr_index     = '0;
   logic [CRC_W-1:0]   fr_crc       = CRC_INIT;

   tx_beat_type tx_expect_q [$];

   int err_count    = 0;
   int items_sent   = 0;
   int req_seen     = 0;
   int beats_seen   = 0;
   int packets_seen = 0;
   int writes_seen  = 0;
   bit burst_mode   = 1'b0;
   bit hold_done    = 1'b0;

   servo_packet_framer_crc16_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock.
   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // CRC-16 update, one data bit at a time from the MSB.
   function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] c,
                                                   input logic [BYTE_W-1:0] d);
      logic [CRC_W-1:0] r;
      logic             fb;
      r = c;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = r[CRC_W-1] ^ d[i];
         r  = {r[CRC_W-2:0], 1'b0};
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   // Parameter count as the framer uses it: saturated to 1..MAX_PARAMS.
   function automatic logic [COUNT_W-1:0] eff_limit(input logic [COUNT_W-1:0] c);
      if (c == '0) begin
         return COUNT_W'(1);
      end
      return (c > MAX_COUNT) ? MAX_COUNT : c;
   endfunction

   // Queue a data byte that also feeds the running CRC.
   function automatic void push_data(input logic [BYTE_W-1:0] b);
      tx_beat_type beat;
      beat.tx_byte    = b;
      beat.packet_end = 1'b0;
      fr_crc = crc16_next(fr_crc, b);
      tx_expect_q.push_back(beat);
   endfunction

   // Work out the packet bytes that one parameter transaction causes.
   function automatic void frame_param(input logic [BYTE_W-1:0] p,
                                       input logic pin_en,
                                       input logic [BYTE_W-1:0] pin_id,
                                       input logic [BYTE_W-1:0] pin_len);
      logic [COUNT_W-1:0] limit;
      logic [LEN_W-1:0]   len;
      tx_beat_type        beat;
      limit = eff_limit(cfg_count);
      if (fr_index == '0) begin
         len    = LEN_W'(limit) + LEN_EXTRA;
         fr_crc = CRC_INIT;
         push_data(HDR_SYNC);
         push_data(HDR_SYNC);
         push_data(HDR_MARK);
         push_data(HDR_RESERVED);
         push_data(pin_en ? pin_id : cfg_servo_id);
         push_data(pin_en ? pin_len : len[7:0]);
         push_data(len[15:8]);
         push_data(cfg_instr);
      end
      push_data(p);
      fr_index = fr_index + COUNT_W'(1);
      if (fr_index >= limit) begin
         beat.tx_byte    = fr_crc[7:0];
         beat.packet_end = 1'b0;
         tx_expect_q.push_back(beat);
         beat.tx_byte    = fr_crc[15:8];
         beat.packet_end = 1'b1;
         tx_expect_q.push_back(beat);
         fr_index = '0;
         fr_crc   = CRC_INIT;
      end
   endfunction

   // Monitor: mirror register writes, predict on each accepted parameter and
   // check every accepted packet byte against the oldest expectation.
   always @(posedge clock) begin
      tx_beat_type beat;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            writes_seen <= writes_seen + 1;
            case (csr_index)
               REG_SERVO_ID:    cfg_servo_id = csr_data;
               REG_INSTRUCTION: cfg_instr    = csr_data;
               REG_PARAM_COUNT: cfg_count    = csr_data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            frame_param(req_tdata, req_pin_en, req_pin_id, req_pin_len);
            req_seen <= req_seen + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            beats_seen <= beats_seen + 1;
            if (rsp_tlast === 1'b1) begin
               packets_seen <= packets_seen + 1;
            end
            if (tx_expect_q.size() == 0) begin
               $error("unexpected packet byte %02h (tlast %0b)", rsp_tdata, rsp_tlast);
               err_count++;
            end else begin
               beat = tx_expect_q.pop_front();
               if (rsp_tdata !== beat.tx_byte) begin
                  $error("tx_byte mismatch: expected %02h, actual %02h",
                         beat.tx_byte, rsp_tdata);
                  err_count++;
               end
               if (rsp_tlast !== beat.packet_end) begin
                  $error("packet_end mismatch: expected %0b, actual %0b",
                         beat.packet_end, rsp_tlast);
                  err_count++;
               end
            end
         end
      end
   end

   // Receiver: random back-pressure, one long hold-off once the input has
   // seen enough traffic, and a stretch with the output always ready.
   initial begin
      forever begin
         @(posedge clock);
         if (!hold_done && req_seen >= HOLD_START) begin
            rsp_tready <= 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (req_seen >= 300 && req_seen < 380) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Offer one parameter byte, with a random gap ahead of it.
   task automatic send_param(input logic [BYTE_W-1:0] p, input logic pe,
                             input logic [BYTE_W-1:0] pid, input logic [BYTE_W-1:0] plen);
      if (!burst_mode && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tdata   <= p;
      req_pin_en  <= pe;
      req_pin_id  <= pid;
      req_pin_len <= plen;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // One register write transaction.
   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering input and wait until every expected byte has come out.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tx_expect_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Main stimulus: reset, directed table, then random phases.
   initial begin
      int                 pick;
      int                 n_items;
      int                 drain_cycles;
      logic [COUNT_W-1:0] new_count;
      logic [COUNT_W-1:0] limit;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      for (int r = 0; r < PLAN_LEN; r++) begin
         if (PLAN[r].kind == ROW_WRITE) begin
            wait_idle();
            write_reg(PLAN[r].index, PLAN[r].value);
         end else begin
            send_param(PLAN[r].value, PLAN[r].pin_en, PLAN[r].pin_id, PLAN[r].pin_len);
         end
      end

      // Random phases: new settings, then mostly whole packets of random bytes.
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            new_count = MAX_COUNT;
         end else if (pick < 12) begin
            new_count = '0;
         end else if (pick < 16) begin
            new_count = '1;
         end else if (pick < 20) begin
            new_count = COUNT_W'($urandom_range(65, 126));
         end else begin
            new_count = COUNT_W'($urandom_range(1, 8));
         end
         write_reg(REG_PARAM_COUNT, {1'($urandom_range(0, 1)), new_count});
         if ($urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 3) == 0) begin
               write_reg(REG_SERVO_ID, 8'($urandom_range(253, 255)));
            end else begin
               write_reg(REG_SERVO_ID, 8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_INSTRUCTION, 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 9) == 0) begin
            write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
         end

         // Close any open packet, add whole ones, and now and then cut short.
         limit   = eff_limit(cfg_count);
         n_items = (fr_index < limit) ? int'(limit - fr_index) : 1;
         if (limit <= 8) begin
            n_items += $urandom_range(0, 2) * int'(limit);
         end
         if ($urandom_range(0, 99) < 15) begin
            n_items = $urandom_range(1, n_items);
         end
         repeat (n_items) begin
            burst_mode = (items_sent >= 250 && items_sent < 330);
            send_param(8'($urandom_range(0, 255)), 1'b0, 8'h00, 8'h00);
         end
      end

      // Drain the output.
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      @(posedge clock);
      while (tx_expect_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (16) @(posedge clock);
      if (tx_expect_q.size() != 0) begin
         $error("%0d expected packet bytes never arrived", tx_expect_q.size());
         err_count++;
      end

      $display("Sent %0d parameter bytes and %0d register writes; checked %0d packet bytes",
               items_sent, writes_seen, beats_seen);
      $display("in %0d finished packets, with back-pressure and one long output stall.",
               packets_seen);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
